@@ hw/rtl/push_button_dimmer_control_assert.svh @@
// ----------------------------------------------------------------------------
// push_button_dimmer_control_assert.svh
// Assertion macros shared by the dimmer RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PUSH_BUTTON_DIMMER_CONTROL_ASSERT_SVH
`define PUSH_BUTTON_DIMMER_CONTROL_ASSERT_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define PBDC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("pbdc assertion failed");

// implication checked in the cycle after the antecedent
`define PBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pbdc assertion failed");

`else

`define PBDC_ASSERT(label, clk, rst_n, prop)
`define PBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/pbdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdc_pkg
// Types, register codes and reset constants of the push button dimmer.
// ----------------------------------------------------------------------------
package pbdc_pkg;

  localparam int TimeBitsDef = 32;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 16;

  // register reset values
  localparam logic [7:0]  MinLevelRst   = 8'd10;
  localparam logic [7:0]  MaxLevelRst   = 8'd255;
  localparam logic [15:0] DimStepRst    = 16'd10;
  localparam logic [15:0] HoldRst       = 16'd1000;
  localparam logic [15:0] FadeStepRst   = 16'd5;
  localparam logic [15:0] PressMinRst   = 16'd50;
  localparam logic [15:0] PressMaxRst   = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_LEVEL    = 3'd0,
    REG_MAX_LEVEL    = 3'd1,
    REG_DIM_STEP_MS  = 3'd2,
    REG_HOLD_MS      = 3'd3,
    REG_FADE_STEP_MS = 3'd4,
    REG_PRESS_MIN_MS = 3'd5,
    REG_PRESS_MAX_MS = 3'd6
  } pbdc_reg_e;

  typedef struct packed {
    logic [7:0]  min_level;
    logic [7:0]  max_level;
    logic [15:0] dim_step_ms;
    logic [15:0] hold_ms;
    logic [15:0] fade_step_ms;
    logic [15:0] press_min_ms;
    logic [15:0] press_max_ms;
  } pbdc_cfg_t;

  typedef struct packed {
    logic button_pressed;
  } pbdc_in_t;

  typedef struct packed {
    logic [7:0] dmx_level;
    logic       lamp_on;
    logic       manual_dimming;
    logic       auto_fading;
  } pbdc_out_t;

endpackage

@@ hw/rtl/pbdc_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdc_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pbdc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/pbdc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdc_cfg
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module pbdc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pbdc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pbdc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output pbdc_pkg::pbdc_cfg_t             cfg_o
);

  pbdc_pkg::pbdc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pbdc_pkg::pbdc_reg_e'(cfg_idx_i))
        pbdc_pkg::REG_MIN_LEVEL:    cfg_d.min_level    = cfg_wdata_i[7:0];
        pbdc_pkg::REG_MAX_LEVEL:    cfg_d.max_level    = cfg_wdata_i[7:0];
        pbdc_pkg::REG_DIM_STEP_MS:  cfg_d.dim_step_ms  = cfg_wdata_i;
        pbdc_pkg::REG_HOLD_MS:      cfg_d.hold_ms      = cfg_wdata_i;
        pbdc_pkg::REG_FADE_STEP_MS: cfg_d.fade_step_ms = cfg_wdata_i;
        pbdc_pkg::REG_PRESS_MIN_MS: cfg_d.press_min_ms = cfg_wdata_i;
        pbdc_pkg::REG_PRESS_MAX_MS: cfg_d.press_max_ms = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level    <= pbdc_pkg::MinLevelRst;
      cfg_q.max_level    <= pbdc_pkg::MaxLevelRst;
      cfg_q.dim_step_ms  <= pbdc_pkg::DimStepRst;
      cfg_q.hold_ms      <= pbdc_pkg::HoldRst;
      cfg_q.fade_step_ms <= pbdc_pkg::FadeStepRst;
      cfg_q.press_min_ms <= pbdc_pkg::PressMinRst;
      cfg_q.press_max_ms <= pbdc_pkg::PressMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/pbdc_tick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdc_tick
// Dimmer state and its one-tick update: edge capture, press classification,
// manual ramp step and fade step.
// ----------------------------------------------------------------------------
`include "push_button_dimmer_control_assert.svh"

module pbdc_tick #(
  parameter int TIME_BITS = pbdc_pkg::TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 button_i,
  input  pbdc_pkg::pbdc_cfg_t  cfg_i,
  output pbdc_pkg::pbdc_out_t  res_o
);

  logic [TIME_BITS-1:0] now_q, t_last_q, t_before_q, last_chg_q;
  logic [TIME_BITS-1:0] now_d, t_last_d, t_before_d, last_chg_d;
  logic                 lvl_last_q, lvl_before_q, pending_q, light_q;
  logic                 lvl_last_d, lvl_before_d, pending_d, light_d;
  logic                 ramp_up_q, ramp_act_q, fade_act_q, off_after_q;
  logic                 ramp_up_d, ramp_act_d, fade_act_d, off_after_d;
  logic [7:0]           level_q, target_q, saved_q;
  logic [7:0]           level_d, target_d, saved_d;
  logic [15:0]          wait_q, wait_d;

  // combinational intermediates
  logic                 is_edge, pending1, cls_ok, long_press, short_press;
  logic [TIME_BITS-1:0] gap, since_last, elapsed, lc1;
  logic [7:0]           level1, level2, target1;
  logic                 light1, ramp_up1, ramp_act1, fade_act1, fade_act2;
  logic                 man_run, at_min, at_max, step_mid, step_min, step_max;
  logic [15:0]          wait1, wait_dec;
  logic [7:0]           min_l, max_l;

  assign min_l = cfg_i.min_level;
  assign max_l = cfg_i.max_level;

  always_comb begin
    // edge capture
    is_edge      = button_i != lvl_last_q;
    lvl_last_d   = button_i;
    lvl_before_d = is_edge ? lvl_last_q : lvl_before_q;
    t_before_d   = is_edge ? t_last_q : t_before_q;
    t_last_d     = is_edge ? now_q : t_last_q;
    pending1     = is_edge | pending_q;

    // classification
    gap         = t_last_d - t_before_d;
    since_last  = now_q - t_last_d;
    cls_ok      = pending1 && (gap >= TIME_BITS'(cfg_i.press_min_ms));
    long_press  = cls_ok && button_i && light_q &&
                  (since_last >= TIME_BITS'(cfg_i.press_max_ms));
    short_press = cls_ok && !long_press && !button_i && lvl_before_d &&
                  (gap <= TIME_BITS'(cfg_i.press_max_ms));
    pending_d   = pending1 && !(long_press || short_press);

    ramp_up1    = long_press ? !ramp_up_q : ramp_up_q;
    ramp_act1   = long_press | ramp_act_q;
    off_after_d = off_after_q;
    saved_d     = saved_q;
    target1     = target_q;
    fade_act1   = fade_act_q;
    wait1       = wait_q;
    level1      = level_q;
    lc1         = last_chg_q;
    light1      = light_q;
    if (short_press) begin
      saved_d   = level_q;
      fade_act1 = 1'b1;
      wait1     = '0;
      if (light_q) begin
        off_after_d = 1'b1;
        target1     = min_l;
      end else begin
        // switch on at minimum and fade up to the old level
        off_after_d = 1'b0;
        target1     = level_q;
        level1      = min_l;
        lc1         = now_q;
        light1      = 1'b1;
      end
    end

    // manual ramp step
    man_run    = ramp_act1 && button_i;
    ramp_act_d = man_run;
    fade_act2  = man_run ? 1'b0 : fade_act1;
    elapsed    = now_q - lc1;
    at_min     = level1 == min_l;
    at_max     = level1 == max_l;
    step_mid   = man_run && !at_min && !at_max &&
                 (elapsed >= TIME_BITS'(cfg_i.dim_step_ms));
    step_min   = man_run && at_min && (elapsed >= TIME_BITS'(cfg_i.hold_ms));
    step_max   = man_run && !at_min && at_max && (elapsed >= TIME_BITS'(cfg_i.hold_ms));
    level2     = level1;
    ramp_up_d  = ramp_up1;
    last_chg_d = lc1;
    if (step_mid) begin
      level2     = ramp_up1 ? level1 + 8'd1 : level1 - 8'd1;
      last_chg_d = now_q;
    end else if (step_min) begin
      level2     = min_l + 8'd1;
      ramp_up_d  = 1'b1;
      last_chg_d = now_q;
    end else if (step_max) begin
      level2     = max_l - 8'd1;
      ramp_up_d  = 1'b0;
      last_chg_d = now_q;
    end

    // fade step
    wait_dec   = (wait1 != 16'd0) ? wait1 - 16'd1 : wait1;
    level_d    = level2;
    light_d    = light1;
    fade_act_d = fade_act2;
    wait_d     = wait1;
    target_d   = target1;
    if (fade_act2) begin
      wait_d = wait_dec;
      if (wait_dec == 16'd0) begin
        if (level2 != target1) begin
          level_d    = (level2 < target1) ? level2 + 8'd1 : level2 - 8'd1;
          last_chg_d = now_q;
          wait_d     = cfg_i.fade_step_ms;
        end else begin
          if (off_after_d) begin
            light_d     = 1'b0;
            off_after_d = 1'b0;
            level_d     = saved_d;
            last_chg_d  = now_q;
          end
          fade_act_d = 1'b0;
        end
      end
    end

    now_d = now_q + TIME_BITS'(1);

    res_o.dmx_level      = light_d ? level_d : 8'd0;
    res_o.lamp_on        = light_d;
    res_o.manual_dimming = ramp_act_d;
    res_o.auto_fading    = fade_act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      t_last_q     <= '0;
      t_before_q   <= '0;
      last_chg_q   <= '0;
      lvl_last_q   <= 1'b0;
      lvl_before_q <= 1'b0;
      pending_q    <= 1'b0;
      light_q      <= 1'b0;
      ramp_up_q    <= 1'b0;
      ramp_act_q   <= 1'b0;
      fade_act_q   <= 1'b0;
      off_after_q  <= 1'b0;
      level_q      <= pbdc_pkg::MaxLevelRst;
      target_q     <= '0;
      saved_q      <= '0;
      wait_q       <= '0;
    end else if (step_i) begin
      now_q        <= now_d;
      t_last_q     <= t_last_d;
      t_before_q   <= t_before_d;
      last_chg_q   <= last_chg_d;
      lvl_last_q   <= lvl_last_d;
      lvl_before_q <= lvl_before_d;
      pending_q    <= pending_d;
      light_q      <= light_d;
      ramp_up_q    <= ramp_up_d;
      ramp_act_q   <= ramp_act_d;
      fade_act_q   <= fade_act_d;
      off_after_q  <= off_after_d;
      level_q      <= level_d;
      target_q     <= target_d;
      saved_q      <= saved_d;
      wait_q       <= wait_d;
    end
  end

  // a ramp only runs while the lamp is lit
  `PBDC_ASSERT(a_ramp_needs_light, clk_i, rst_ni, !ramp_act_q || light_q)
  // tick time advances by exactly one per item
  `PBDC_ASSERT_NEXT(a_time_step, clk_i, rst_ni, step_i,
                    now_q == $past(now_q) + TIME_BITS'(1))

endmodule

@@ hw/rtl/push_button_dimmer_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// push_button_dimmer_control
// One-button touch dimmer for a single lamp channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one beat per millisecond tick with the sampled button level.
//   out_o returns one beat per input beat: lamp level (0 while off), lamp on,
//   manual ramp active and automatic fade active after that tick.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   no beat is in flight; it takes effect on the next tick.
// Timing and throughput:
//   a result enters the output register in the cycle after its input beat is
//   taken; one beat per cycle is sustained while out_o.ready is high, since the
//   whole tick update is combinational between state and output registers.
// Reset:
//   rst_ni clears the tick time, edge history and lamp state; the level starts
//   at the default maximum and registers take their default values.
// Stall:
//   while a result waits on out_o, a new beat is still taken in the cycle the
//   receiver drains it; otherwise in_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "push_button_dimmer_control_assert.svh"

module push_button_dimmer_control #(
  parameter int TIME_BITS = pbdc_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbdc_pkg::CfgDataW-1:0] cfg_wdata_i,
  pbdc_chan_if.sink                     in_i,
  pbdc_chan_if.source                   out_o
);

  pbdc_pkg::pbdc_cfg_t cfg;
  pbdc_pkg::pbdc_out_t res;
  pbdc_pkg::pbdc_out_t out_data_q;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  pbdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pbdc_tick #(
    .TIME_BITS (TIME_BITS)
  ) u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .button_i (in_i.data.button_pressed),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // output slot is free when empty or drained this cycle
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // a pending result that is not taken blocks new beats
  `PBDC_ASSERT(a_stall_blocks_input, clk_i, rst_ni,
               !(out_valid_q && !out_o.ready) || !in_i.ready)
  // every accepted beat shows up as a result next cycle
  `PBDC_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, accept, out_valid_q)

endmodule
